>>> hdl/hrls_pkg.sv
// Shared types and constants of the horizontal run-length smoothing block.
`timescale 1ns / 1ps
package hrls_pkg;

    localparam int MAX_LINE  = 4096;
    localparam int LEN_W     = $clog2(MAX_LINE + 1);
    localparam int CFG_IDX_W = 1;
    localparam int EDGE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE     = 1'd1;

    localparam logic [LEN_W-1:0]  GAP_RESET  = LEN_W'(23);
    localparam logic [EDGE_W-1:0] EDGE_RESET = '0;
    localparam logic [LEN_W-1:0]  LEN_MAX    = LEN_W'(MAX_LINE);

    // One queued event: an optional closed white run, then an optional black pixel.
    typedef struct packed {
        logic             w_valid;
        logic             w_black;
        logic [LEN_W-1:0] w_len;
        logic             w_done;
        logic             b_valid;
        logic             b_done;
    } t_event;

    typedef struct packed {
        logic              valid;
        logic [CFG_IDX_W-1:0] index;
        logic [LEN_W-1:0]  data;
    } t_cfg_wr;

endpackage

>>> hdl/hrls_front.sv
// Front end: configuration registers, white-run counter and run classification.
`timescale 1ns / 1ps
module hrls_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrls_pkg::t_cfg_wr i_cfg,
    input  logic            i_pix_valid,
    input  logic            i_pix_black,
    input  logic            i_pix_end,
    input  logic            i_q_full,
    output logic            o_pix_ready,
    output logic            o_push,
    output hrls_pkg::t_event o_event
);
    import hrls_pkg::*;

    logic [LEN_W-1:0]  r_gap, n_gap;
    logic [EDGE_W-1:0] r_edge, n_edge;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_start, n_start;

    logic             accept;
    logic [LEN_W-1:0] cnt_inc;
    logic [LEN_W-1:0] close_len;
    logic             lead_ok;
    logic             trail_ok;

    assign o_pix_ready = !i_q_full;
    assign accept      = i_pix_valid && !i_q_full;
    assign cnt_inc     = (r_cnt < LEN_MAX) ? r_cnt + LEN_W'(1) : r_cnt;

    // A white pixel that ends the line closes the run including itself.
    assign close_len = i_pix_black ? r_cnt : cnt_inc;
    assign lead_ok   = !(r_start && !r_edge[0]);
    assign trail_ok  = !(!i_pix_black && !r_edge[1]);

    always_comb begin
        o_event.w_valid = i_pix_black ? (r_cnt != '0) : 1'b1;
        o_event.w_black = lead_ok && trail_ok && (close_len < r_gap);
        o_event.w_len   = close_len;
        o_event.w_done  = !i_pix_black;
        o_event.b_valid = i_pix_black;
        o_event.b_done  = i_pix_end;
    end

    assign o_push = accept && (i_pix_black || i_pix_end);

    always_comb begin
        n_gap   = r_gap;
        n_edge  = r_edge;
        n_cnt   = r_cnt;
        n_start = r_start;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GAP_THRESHOLD: n_gap  = i_cfg.data;
                CFG_EDGE_MODE:     n_edge = i_cfg.data[EDGE_W-1:0];
                default: ;
            endcase
        end
        if (accept) begin
            if (i_pix_black) begin
                n_cnt   = '0;
                n_start = i_pix_end;
            end else if (i_pix_end) begin
                n_cnt   = '0;
                n_start = 1'b1;
            end else begin
                n_cnt   = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= GAP_RESET;
            r_edge  <= EDGE_RESET;
            r_cnt   <= '0;
            r_start <= 1'b1;
        end else begin
            r_gap   <= n_gap;
            r_edge  <= n_edge;
            r_cnt   <= n_cnt;
            r_start <= n_start;
        end
    end

endmodule

>>> hdl/hrls_fifo.sv
// Event queue between the front end and the run emitter.
`timescale 1ns / 1ps
module hrls_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hrls_pkg::t_event i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output hrls_pkg::t_event o_head
);
    import hrls_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_event           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hdl/hrls_back.sv
// Back end: expands queued events into runs and holds them in the output register.
`timescale 1ns / 1ps
module hrls_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  hrls_pkg::t_event i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_run_black,
    output logic [hrls_pkg::LEN_W-1:0] o_run_length,
    output logic            o_line_done,
    output logic            o_last
);
    import hrls_pkg::*;

    logic             r_phase, n_phase;
    logic             r_ov, n_ov;
    logic             r_black;
    logic [LEN_W-1:0] r_len;
    logic             r_done;
    logic             r_last;

    logic             load;
    logic             sel_white;
    logic             fin;
    logic             c_black;
    logic [LEN_W-1:0] c_len;
    logic             c_done;

    // Phase 0 emits the white run when present; otherwise, or in phase 1, the black pixel.
    assign sel_white = !r_phase && i_head.w_valid;
    assign fin       = !(sel_white && i_head.b_valid);
    assign c_black   = sel_white ? i_head.w_black : 1'b1;
    assign c_len     = sel_white ? i_head.w_len : LEN_W'(1);
    assign c_done    = sel_white ? i_head.w_done : i_head.b_done;

    assign load  = i_q_valid && (!r_ov || i_ready);
    assign o_pop = load && fin;

    always_comb begin
        n_phase = r_phase;
        n_ov    = r_ov;
        if (load) begin
            n_phase = !fin;
            n_ov    = 1'b1;
        end else if (i_ready) begin
            n_ov    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_black <= c_black;
            r_len   <= c_len;
            r_done  <= c_done;
            r_last  <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
    end

    assign o_valid      = r_ov;
    assign o_run_black  = r_black;
    assign o_run_length = r_len;
    assign o_line_done  = r_done;
    assign o_last       = r_last;

    // Second phase only exists for an event still at the head with both parts.
    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_q_valid && i_head.w_valid && i_head.b_valid))
        else $error("second phase without a split event at the head");

    // A run never leaves with zero length.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_len != '0))
        else $error("zero-length run on output");

    // A white run followed by its black pixel can never close the line.
    a_split_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_last) |-> !r_done)
        else $error("line closed by a run that is not the last of its pixel");

endmodule

>>> hdl/horizontal_run_length_smoothing.sv
// Top level of the horizontal run-length smoothing block.
//
// Usage:
//   Pixels of a scan line enter on the slave stream, one per transfer, in
//   raster order: tdata[0] is the pixel (1 black, 0 white), tlast marks the
//   last pixel of the line. Runs leave on the master stream: tdata carries
//   the colour and the length, tlast marks the run that ends the line, and
//   tuser marks the last run caused by one input pixel. A white run shorter
//   than gap_threshold is sent as black; edge_mode bit 0 / bit 1 allow the
//   leading / trailing run of a line to be filled.
// Rate and flow:
//   One pixel per clock is accepted while the event queue has room. A run
//   passes through the event queue into the output register once the pixel
//   that closes it is transferred. A black pixel after a white run yields
//   two runs, so its event stays at the queue head until both are sent; the
//   QUEUE_DEPTH queue of events absorbs this and output stalls.
// Reset and stalls:
//   Reset empties the queue and output register, sets gap_threshold to 23,
//   edge_mode to 0 and starts a fresh line. When the receiver stalls, the
//   output holds; once the queue fills, o_s_tready drops.
//   Configuration writes are accepted every cycle; write them only while idle.
`timescale 1ns / 1ps
module horizontal_run_length_smoothing #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: tdata = {7'b0, pixel_black}, tlast = line_end
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    // master stream: tdata = {2'b0, run_length[12:0], run_black}
    // tlast = line_done, tuser = last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hrls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hrls_pkg::LEN_W-1:0]     i_cfg_data
);
    import hrls_pkg::*;

    t_cfg_wr          cfg_wr;
    t_event           push_event;
    t_event           head_event;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    logic             run_black;
    logic [LEN_W-1:0] run_length;

    // Registers take a write in any cycle.
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // Classify each pixel and queue the runs it closes.
    hrls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_pix_valid (i_s_tvalid),
        .i_pix_black (i_s_tdata[0]),
        .i_pix_end   (i_s_tlast),
        .i_q_full    (q_full),
        .o_pix_ready (o_s_tready),
        .o_push      (push),
        .o_event     (push_event)
    );

    // Decouple pixel intake from run emission.
    hrls_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_event),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_event)
    );

    // Expand events into one or two runs each and drive the master stream.
    hrls_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_head       (head_event),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_run_black  (run_black),
        .o_run_length (run_length),
        .o_line_done  (o_m_tlast),
        .o_last       (o_m_tuser)
    );

    assign o_m_tdata = {2'b00, run_length, run_black};

endmodule
